>>> rtl/bfm_pkg.sv
// ---------------------------------------------------------------------------
// Binaural FIR mixer package
// Shared widths, command and bank codes, and request, response and
// datapath types for the binaural FIR mixer.
// ---------------------------------------------------------------------------
package bfm_pkg;

   localparam int TAPS_DEFAULT = 200;
   localparam int SAMPLE_W     = 16;
   localparam int TAP_IDX_W    = 8;
   localparam int NUM_BANKS    = 4;
   localparam int PROD_W       = 2 * SAMPLE_W;
   localparam int FRAC_BITS    = 15;
   localparam int SAT_MAX      = 32767;
   localparam int SAT_MIN      = -32768;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_PROCESS = 1'b1;

   // coefficient banks
   localparam logic [1:0] BANK_LL = 2'd0;
   localparam logic [1:0] BANK_LR = 2'd1;
   localparam logic [1:0] BANK_RL = 2'd2;
   localparam logic [1:0] BANK_RR = 2'd3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic                   command;
      logic [1:0]             filter_select;
      logic [TAP_IDX_W-1:0]   tap_index;
      sample_type             coefficient;
      sample_type             left_sample;
      sample_type             right_sample;
      logic                   end_of_stream;
   } req_type;

   typedef struct packed {
      sample_type out_left;
      sample_type out_right;
      logic       left_clipped;
      logic       right_clipped;
      logic       last;
   } rsp_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } hist_pair_type;

   typedef logic [NUM_BANKS-1:0][SAMPLE_W-1:0] coef_quad_type;

   typedef struct packed {
      logic clear;   // start a new pair: zero the accumulators
      logic valid;   // memory read data is a tap to accumulate
      logic keep;    // history slot has been written since reset
   } mac_ctrl_type;

   typedef struct packed {
      sample_type value;
      logic       clipped;
   } sat_lane_type;

   typedef struct packed {
      sat_lane_type left;
      sat_lane_type right;
   } sat_result_type;

endpackage

>>> rtl/bfm_chan_if.sv
// ---------------------------------------------------------------------------
// Binaural FIR mixer channel
// Valid/ready channel carrying one request or response per handshake.
// ---------------------------------------------------------------------------
interface bfm_chan_if #(
   parameter type payload_type = bfm_pkg::req_type
);

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

>>> rtl/bfm_mac.sv
// ---------------------------------------------------------------------------
// Binaural FIR mixer multiply-accumulate
// Four multiplies per tap, two accumulators, floor shift and saturation.
// ---------------------------------------------------------------------------
module bfm_mac #(
   parameter int TAPS = bfm_pkg::TAPS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bfm_pkg::mac_ctrl_type   ctrl,
   input  bfm_pkg::coef_quad_type  coef,
   input  bfm_pkg::hist_pair_type  hist,
   output logic                    busy,
   output bfm_pkg::sat_result_type result
);

   localparam int ACC_W  = bfm_pkg::PROD_W + 1 + $clog2(TAPS);
   localparam int Q_W    = ACC_W - bfm_pkg::FRAC_BITS;
   localparam int PAIR_W = bfm_pkg::PROD_W + 1;
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(bfm_pkg::SAT_MAX);
   localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(bfm_pkg::SAT_MIN);

   bfm_pkg::sample_type left_smp, right_smp;

   logic signed [bfm_pkg::PROD_W-1:0] prod_ll_ff, prod_lr_ff, prod_rl_ff, prod_rr_ff;
   logic signed [bfm_pkg::PROD_W-1:0] prod_ll_in, prod_lr_in, prod_rl_in, prod_rr_in;
   logic                              prod_valid_ff;

   logic signed [PAIR_W-1:0] pair_left, pair_right;
   logic signed [ACC_W-1:0]  acc_left_ff, acc_right_ff;
   logic signed [ACC_W-1:0]  acc_left_in, acc_right_in;
   logic signed [Q_W-1:0]    q_left, q_right;

   function automatic bfm_pkg::sat_lane_type saturate(input logic signed [Q_W-1:0] q);
      bfm_pkg::sat_lane_type lane;
      if (q > Q_MAX) begin
         lane.value   = bfm_pkg::SAMPLE_W'(bfm_pkg::SAT_MAX);
         lane.clipped = 1'b1;
      end else if (q < Q_MIN) begin
         lane.value   = bfm_pkg::SAMPLE_W'(bfm_pkg::SAT_MIN);
         lane.clipped = 1'b1;
      end else begin
         lane.value   = q[bfm_pkg::SAMPLE_W-1:0];
         lane.clipped = 1'b0;
      end
      return lane;
   endfunction

   // slots never written since reset read as silence
   assign left_smp  = ctrl.keep ? hist.left  : '0;
   assign right_smp = ctrl.keep ? hist.right : '0;

   assign prod_ll_in = $signed(coef[bfm_pkg::BANK_LL]) * left_smp;
   assign prod_lr_in = $signed(coef[bfm_pkg::BANK_LR]) * right_smp;
   assign prod_rl_in = $signed(coef[bfm_pkg::BANK_RL]) * left_smp;
   assign prod_rr_in = $signed(coef[bfm_pkg::BANK_RR]) * right_smp;

   always_ff @(posedge clock) begin
      prod_ll_ff <= prod_ll_in;
      prod_lr_ff <= prod_lr_in;
      prod_rl_ff <= prod_rl_in;
      prod_rr_ff <= prod_rr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.valid;
      end
   end

   assign pair_left    = PAIR_W'(prod_ll_ff) + PAIR_W'(prod_lr_ff);
   assign pair_right   = PAIR_W'(prod_rl_ff) + PAIR_W'(prod_rr_ff);
   assign acc_left_in  = acc_left_ff  + ACC_W'(pair_left);
   assign acc_right_in = acc_right_ff + ACC_W'(pair_right);

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         acc_left_ff  <= '0;
         acc_right_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_left_ff  <= acc_left_in;
         acc_right_ff <= acc_right_in;
      end
   end

   // arithmetic shift gives floor rounding
   assign q_left  = Q_W'(acc_left_ff  >>> bfm_pkg::FRAC_BITS);
   assign q_right = Q_W'(acc_right_ff >>> bfm_pkg::FRAC_BITS);

   assign result.left  = saturate(q_left);
   assign result.right = saturate(q_right);
   assign busy         = prod_valid_ff;

endmodule

>>> rtl/binaural_fir_mixer.sv
// Flow: requests are taken only while idle, and a load leaves the block idle;
//   a sample pair shows its response once every tap has been accumulated, and
//   no new request is taken until then. One tap per cycle goes through the
//   single read port of the history and coefficient memories.
// Reset: synchronous; histories read as zero until written, coefficients are
//   undefined until loaded, and no clearing pass is needed.
// ---------------------------------------------------------------------------
// Binaural FIR mixer
// Loads four FIR coefficient banks and turns each stereo sample pair into a
// saturated binaural pair from a circular sample history.
// ---------------------------------------------------------------------------
module binaural_fir_mixer #(
   parameter int TAPS = bfm_pkg::TAPS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   bfm_chan_if.sink   req_chan,
   bfm_chan_if.source rsp_chan
);

   localparam int ADDR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int FILL_W = $clog2(TAPS + 1);
   localparam logic [ADDR_W-1:0] TAP_LAST  = ADDR_W'(TAPS - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TAPS);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   bfm_pkg::req_type req_data;
   logic             req_accept, load_accept, proc_accept, tap_in_range;
   logic [ADDR_W-1:0] coef_waddr;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              last_ff, last_in;

   logic              rd_valid_ff, rd_keep_ff;
   bfm_pkg::hist_pair_type hist_q_ff;
   bfm_pkg::coef_quad_type coef_q_ff;

   bfm_pkg::hist_pair_type hist_mem [TAPS];
   bfm_pkg::coef_quad_type coef_mem [TAPS];

   bfm_pkg::mac_ctrl_type   mac_ctrl;
   bfm_pkg::sat_result_type mac_result;
   logic                    mac_busy;

   logic             rsp_load;
   logic             rsp_valid_ff;
   bfm_pkg::rsp_type rsp_data_ff;

   assign req_data     = req_chan.data;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_chan.valid && req_chan.ready;
   assign tap_in_range = 32'(req_data.tap_index) < 32'(TAPS);
   assign load_accept  = req_accept && (req_data.command == bfm_pkg::CMD_LOAD);
   assign proc_accept  = req_accept && (req_data.command == bfm_pkg::CMD_PROCESS);
   assign coef_waddr   = ADDR_W'(req_data.tap_index);

   // coefficient memory: lane write on load, one tap read per cycle
   always_ff @(posedge clock) begin
      if (load_accept && tap_in_range) begin
         coef_mem[coef_waddr][req_data.filter_select] <= req_data.coefficient;
      end
      coef_q_ff <= coef_mem[k_ff];
   end

   // history memory: newest pair written at the pointer, read walking backwards
   always_ff @(posedge clock) begin
      if (proc_accept) begin
         hist_mem[ptr_ff] <= '{left: req_data.left_sample, right: req_data.right_sample};
      end
      hist_q_ff <= hist_mem[pos_ff];
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      pos_in   = pos_ff;
      ptr_in   = ptr_ff;
      fill_in  = fill_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (proc_accept) begin
               state_in = ST_RUN;
               k_in     = '0;
               pos_in   = ptr_ff;
               ptr_in   = (ptr_ff == TAP_LAST) ? '0 : ptr_ff + 1'b1;
               last_in  = req_data.end_of_stream;
               if (fill_ff != FILL_FULL) begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         ST_RUN: begin
            k_in   = k_ff + 1'b1;
            pos_in = (pos_ff == '0) ? TAP_LAST : pos_ff - 1'b1;
            if (k_ff == TAP_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !mac_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ptr_ff      <= '0;
         fill_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ptr_ff      <= ptr_in;
         fill_ff     <= fill_in;
         rd_valid_ff <= (state_ff == ST_RUN);
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      pos_ff     <= pos_in;
      last_ff    <= last_in;
      rd_keep_ff <= FILL_W'(pos_ff) < fill_ff;
   end

   assign mac_ctrl.clear = proc_accept;
   assign mac_ctrl.valid = rd_valid_ff;
   assign mac_ctrl.keep  = rd_keep_ff;

   bfm_mac #(
      .TAPS (TAPS)
   ) u_bfm_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .coef   (coef_q_ff),
      .hist   (hist_q_ff),
      .busy   (mac_busy),
      .result (mac_result)
   );

   // hold the finished pair until the output register is free
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.out_left      <= mac_result.left.value;
         rsp_data_ff.out_right     <= mac_result.right.value;
         rsp_data_ff.left_clipped  <= mac_result.left.clipped;
         rsp_data_ff.right_clipped <= mac_result.right.clipped;
         rsp_data_ff.last          <= last_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

>>> rtl/bfm_checker.sv
// ---------------------------------------------------------------------------
// Binaural FIR mixer port checker
// Watches the request and response channels of the mixer over time.
// ---------------------------------------------------------------------------
module bfm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_command,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bfm_pkg::rsp_type rsp_data
);

   // a stalled response stays offered
   rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // a stalled response keeps its payload
   rsp_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // a sample pair request occupies the filter: no request taken next cycle
   busy_after_pair: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == bfm_pkg::CMD_PROCESS) |=> !req_ready)
      else $error("request accepted while a pair is being filtered");

   // a clipped output sits at one of the rails
   clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.left_clipped || rsp_data.right_clipped) |->
         (!rsp_data.left_clipped
            || rsp_data.out_left == bfm_pkg::sample_type'(bfm_pkg::SAT_MAX)
            || rsp_data.out_left == bfm_pkg::sample_type'(bfm_pkg::SAT_MIN))
         && (!rsp_data.right_clipped
            || rsp_data.out_right == bfm_pkg::sample_type'(bfm_pkg::SAT_MAX)
            || rsp_data.out_right == bfm_pkg::sample_type'(bfm_pkg::SAT_MIN)))
      else $error("clip flag set on an output off the rail");

endmodule

bind binaural_fir_mixer bfm_checker u_bfm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_command (req_chan.data.command),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_data    (rsp_chan.data)
);

>>> tb/tb_binaural_fir_mixer.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Binaural FIR mixer testbench
// Clears every coefficient first. A table of directed requests then covers
// the sample and coefficient rails, clipping, out-of-range taps and the
// end-of-stream echo. Random loads and sample pairs follow. Each response is
// checked against a scoreboard fed by a bit-exact model of the mixer, or by a
// typed row's own expected pair. Gaps are random on both channels, with one
// long receiver hold-off and one sender pause letting outstanding pairs drain.
// ---------------------------------------------------------------------------
module tb_binaural_fir_mixer;

   localparam int  TAPS            = bfm_pkg::TAPS_DEFAULT;
   localparam time CLK_PERIOD      = 20;
   localparam int  RANDOM_ITEMS    = 280;
   localparam int  HOLD_OFF_CYCLES = 3000;
   localparam int  HOLD_OFF_AFTER  = 40;
   localparam int  REPORT_LIMIT    = 10;

   typedef struct {
      bfm_pkg::req_type item;
      bit               typed;
      bfm_pkg::rsp_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   bfm_chan_if #(.payload_type(bfm_pkg::req_type)) req_if ();
   bfm_chan_if #(.payload_type(bfm_pkg::rsp_type)) rsp_if ();

   binaural_fir_mixer #(
      .TAPS(TAPS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // mixer model state
   bfm_pkg::sample_type coef_bank [bfm_pkg::NUM_BANKS][TAPS];
   bfm_pkg::sample_type hist_left [TAPS];
   bfm_pkg::sample_type hist_right [TAPS];
   int                  hist_head;

   bfm_pkg::rsp_type pending_pairs [$];
   stim_row_type     directed_rows [$];
   int               mismatches;
   int               pairs_received;
   bit               sender_quiet;

   // Floor shift by the fraction bits, then clamp to the sample range.
   function automatic void saturate_q15(input longint sum,
                                        output bfm_pkg::sample_type value,
                                        output logic clipped);
      longint q;
      q = sum >>> bfm_pkg::FRAC_BITS;
      clipped = 1'b0;
      if (q > bfm_pkg::SAT_MAX) begin
         q = bfm_pkg::SAT_MAX;
         clipped = 1'b1;
      end else if (q < bfm_pkg::SAT_MIN) begin
         q = bfm_pkg::SAT_MIN;
         clipped = 1'b1;
      end
      value = bfm_pkg::sample_type'(q);
   endfunction

   // Apply one request to the model; returns 1 when it yields a pair.
   function automatic bit mix_request(input bfm_pkg::req_type r,
                                      output bfm_pkg::rsp_type pair);
      longint sum_left;
      longint sum_right;
      int     pos;
      int     k;
      pair = '0;
      if (r.command == bfm_pkg::CMD_LOAD) begin
         if (r.tap_index < TAPS)
            coef_bank[r.filter_select][r.tap_index] = r.coefficient;
         return 1'b0;
      end
      hist_left[hist_head]  = r.left_sample;
      hist_right[hist_head] = r.right_sample;
      sum_left  = 0;
      sum_right = 0;
      pos = hist_head;
      for (k = 0; k < TAPS; k++) begin
         sum_left  += longint'(coef_bank[bfm_pkg::BANK_LL][k]) * longint'(hist_left[pos])
                    + longint'(coef_bank[bfm_pkg::BANK_LR][k]) * longint'(hist_right[pos]);
         sum_right += longint'(coef_bank[bfm_pkg::BANK_RL][k]) * longint'(hist_left[pos])
                    + longint'(coef_bank[bfm_pkg::BANK_RR][k]) * longint'(hist_right[pos]);
         pos = (pos == 0) ? TAPS - 1 : pos - 1;
      end
      hist_head = (hist_head == TAPS - 1) ? 0 : hist_head + 1;
      saturate_q15(sum_left, pair.out_left, pair.left_clipped);
      saturate_q15(sum_right, pair.out_right, pair.right_clipped);
      pair.last = r.end_of_stream;
      return 1'b1;
   endfunction

   function automatic stim_row_type load_row(input logic [1:0] bank, input int tap,
                                             input int coef);
      stim_row_type row;
      row.item               = '0;
      row.item.command       = bfm_pkg::CMD_LOAD;
      row.item.filter_select = bank;
      row.item.tap_index     = bfm_pkg::TAP_IDX_W'(tap);
      row.item.coefficient   = bfm_pkg::sample_type'(coef);
      row.typed              = 1'b0;
      row.want               = '0;
      return row;
   endfunction

   function automatic stim_row_type pair_row(input int left, input int right,
                                             input bit eos, input bit typed = 1'b0,
                                             input int want_left = 0,
                                             input int want_right = 0,
                                             input bit left_clip = 1'b0,
                                             input bit right_clip = 1'b0);
      stim_row_type row;
      row.item                    = '0;
      row.item.command            = bfm_pkg::CMD_PROCESS;
      row.item.left_sample        = bfm_pkg::sample_type'(left);
      row.item.right_sample       = bfm_pkg::sample_type'(right);
      row.item.end_of_stream      = eos;
      row.typed                   = typed;
      row.want.out_left           = bfm_pkg::sample_type'(want_left);
      row.want.out_right          = bfm_pkg::sample_type'(want_right);
      row.want.left_clipped       = left_clip;
      row.want.right_clipped      = right_clip;
      row.want.last               = eos;
      return row;
   endfunction

   // Mostly quiet values, some full-range, some pinned to a rail.
   function automatic bfm_pkg::sample_type random_value(input int quiet_span,
                                                        input int loud_pct,
                                                        input int rail_pct);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < rail_pct)
         return ($urandom_range(0, 1) == 0) ? bfm_pkg::sample_type'(bfm_pkg::SAT_MAX)
                                            : bfm_pkg::sample_type'(bfm_pkg::SAT_MIN);
      if (pick < rail_pct + loud_pct)
         return bfm_pkg::sample_type'($urandom);
      return bfm_pkg::sample_type'(int'($urandom_range(0, 2 * quiet_span)) - quiet_span);
   endfunction

   function automatic bfm_pkg::req_type random_request();
      bfm_pkg::req_type r;
      r.command       = ($urandom_range(0, 99) < 35) ? bfm_pkg::CMD_LOAD
                                                     : bfm_pkg::CMD_PROCESS;
      r.filter_select = 2'($urandom_range(0, bfm_pkg::NUM_BANKS - 1));
      r.tap_index     = ($urandom_range(0, 9) == 0)
                        ? bfm_pkg::TAP_IDX_W'($urandom_range(0, 255))
                        : bfm_pkg::TAP_IDX_W'($urandom_range(0, TAPS - 1));
      r.coefficient   = random_value(512, 7, 3);
      r.left_sample   = random_value(2000, 40, 10);
      r.right_sample  = random_value(2000, 40, 10);
      r.end_of_stream = ($urandom_range(0, 15) == 0);
      return r;
   endfunction

   function automatic int sender_gap();
      int pick;
      if (sender_quiet)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      if (pick < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   task automatic report_pair(input string tag, input bfm_pkg::rsp_type want,
                              input bfm_pkg::rsp_type got);
      string want_text;
      string got_text;
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         want_text = $sformatf("L=%0d R=%0d clip=%b%b last=%b", want.out_left,
                               want.out_right, want.left_clipped, want.right_clipped,
                               want.last);
         got_text  = $sformatf("L=%0d R=%0d clip=%b%b last=%b", got.out_left,
                               got.out_right, got.left_clipped, got.right_clipped,
                               got.last);
         $display("%0t %s: expected %s, got %s", $time, tag, want_text, got_text);
      end
   endtask

   // Offer one request, hold until it is taken, then log its expected pair.
   task automatic send_request(input bfm_pkg::req_type item, input bit typed = 1'b0,
                               input bfm_pkg::rsp_type want = '0);
      bfm_pkg::rsp_type pair;
      int               gap;
      req_if.valid <= 1'b1;
      req_if.data  <= item;
      do @(posedge clock); while (!req_if.ready);
      if (mix_request(item, pair))
         pending_pairs.push_back(typed ? want : pair);
      gap = sender_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      bfm_pkg::rsp_type want;
      bfm_pkg::rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         pairs_received++;
         if (pending_pairs.size() == 0) begin
            report_pair("unexpected response", '0, got);
         end else begin
            want = pending_pairs.pop_front();
            if (got.out_left !== want.out_left || got.out_right !== want.out_right ||
                got.left_clipped !== want.left_clipped ||
                got.right_clipped !== want.right_clipped || got.last !== want.last)
               report_pair("response mismatch", want, got);
         end
      end
   end

   // receiver: random ready segments, one long hold-off
   initial begin
      bit held_off;
      int span;
      held_off = 1'b0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (!held_off && pairs_received >= HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if ($urandom_range(0, 99) < 70) begin
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
            rsp_if.ready <= 1'b1;
            repeat (span) @(posedge clock);
         end else begin
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                               : $urandom_range(1, 4);
            rsp_if.ready <= 1'b0;
            repeat (span) @(posedge clock);
         end
      end
   end

   // sender
   initial begin
      int               bank;
      int               tap;
      int               n;
      bfm_pkg::req_type item;
      stim_row_type     row;
      mismatches     = 0;
      pairs_received = 0;
      hist_head      = 0;
      sender_quiet   = 1'b0;
      foreach (coef_bank[b, t]) coef_bank[b][t] = '0;
      foreach (hist_left[t]) begin
         hist_left[t]  = '0;
         hist_right[t] = '0;
      end
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // clear every coefficient before any pair goes in
      for (bank = 0; bank < bfm_pkg::NUM_BANKS; bank++)
         for (tap = 0; tap < TAPS; tap++) begin
            row = load_row(2'(bank), tap, 0);
            send_request(row.item);
         end

      directed_rows.push_back(pair_row(32767, -32768, 1'b0, 1'b1, 0, 0, 1'b0, 1'b0));
      directed_rows.push_back(load_row(bfm_pkg::BANK_LL, 0, -32768));
      directed_rows.push_back(load_row(bfm_pkg::BANK_RR, 0, -32768));
      directed_rows.push_back(pair_row(-32768, -32768, 1'b1, 1'b1, 32767, 32767, 1'b1, 1'b1));
      directed_rows.push_back(pair_row(32767, 32767, 1'b0, 1'b1, -32767, -32767, 1'b0, 1'b0));
      directed_rows.push_back(load_row(bfm_pkg::BANK_LR, 0, -32768));
      directed_rows.push_back(pair_row(-32768, -32768, 1'b0, 1'b1, 32767, 32767, 1'b1, 1'b1));
      directed_rows.push_back(pair_row(32767, 32767, 1'b0, 1'b1, -32768, -32767, 1'b1, 1'b0));
      directed_rows.push_back(load_row(bfm_pkg::BANK_RL, 0, 32767));
      // taps past the end must be dropped, not folded into a neighbour bank
      directed_rows.push_back(load_row(bfm_pkg::BANK_RL, 255, 16'h1234));
      directed_rows.push_back(load_row(bfm_pkg::BANK_LL, TAPS, 32767));
      directed_rows.push_back(load_row(bfm_pkg::BANK_LR, TAPS - 1, 32767));
      directed_rows.push_back(pair_row(1, -1, 1'b0));
      directed_rows.push_back(load_row(bfm_pkg::BANK_LL, 1, 1));
      directed_rows.push_back(pair_row(-1, 0, 1'b1));
      directed_rows.push_back(pair_row(0, 0, 1'b0));
      directed_rows.push_back(load_row(bfm_pkg::BANK_LL, 0, 0));
      directed_rows.push_back(load_row(bfm_pkg::BANK_LR, 0, 0));
      directed_rows.push_back(load_row(bfm_pkg::BANK_RL, 0, 0));
      directed_rows.push_back(load_row(bfm_pkg::BANK_RR, 0, 0));
      directed_rows.push_back(load_row(bfm_pkg::BANK_LR, TAPS - 1, 0));
      directed_rows.push_back(load_row(bfm_pkg::BANK_LL, 1, 0));
      directed_rows.push_back(pair_row(12345, -4321, 1'b1));
      foreach (directed_rows[i])
         send_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0)
            sender_quiet = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) begin
            // pause until the pipeline has drained
            req_if.valid <= 1'b0;
            do @(posedge clock); while (pending_pairs.size() != 0);
         end
         item = random_request();
         send_request(item);
      end

      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_pairs.size() != 0);
      repeat (TAPS + 20) @(posedge clock);
      if (mismatches == 0 && pending_pairs.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> filelist.f
rtl/bfm_pkg.sv
rtl/bfm_chan_if.sv
rtl/bfm_mac.sv
rtl/binaural_fir_mixer.sv
rtl/bfm_checker.sv
tb/tb_binaural_fir_mixer.sv
